>>> sv/ptl_pkg.sv
// ptl_pkg: shared types and codes for the peer table with lru eviction and ttl expiry
// no dependencies; imported by ptl_cell and peer_table_lru_ttl
`default_nettype none

package ptl_pkg;

	// opcodes of an input item
	localparam logic [1:0] OP_ANNOUNCE = 2'd0;
	localparam logic [1:0] OP_SWEEP    = 2'd1;
	localparam logic [1:0] OP_READ     = 2'd2;

	// result status codes
	localparam logic [2:0] ST_REFRESHED  = 3'd0;
	localparam logic [2:0] ST_INSERTED   = 3'd1;
	localparam logic [2:0] ST_EVICTED    = 3'd2;
	localparam logic [2:0] ST_DROPPED    = 3'd3;
	localparam logic [2:0] ST_SWEPT      = 3'd4;
	localparam logic [2:0] ST_READ_OK    = 3'd5;
	localparam logic [2:0] ST_READ_EMPTY = 3'd6;

	// configuration register indexes and reset values
	localparam logic REG_OWN_ID = 1'b0;
	localparam logic REG_TTL_MS = 1'b1;
	localparam logic [31:0] OWN_ID_RESET = 32'd0;
	localparam logic [31:0] TTL_MS_RESET = 32'd30000;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] peer_id;
		logic [31:0] peer_ip;
		logic [31:0] name_ref;
		logic [31:0] now_ms;
		logic [3:0]  read_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  peer_count;
		logic [4:0]  removed_count;
		logic [31:0] entry_id;
		logic [31:0] entry_ip;
		logic [31:0] entry_name_ref;
		logic [31:0] entry_last_seen;
	} out_item_t;

	// one table entry as held by a cell
	typedef struct packed {
		logic [31:0] id;
		logic [31:0] ip;
		logic [31:0] name_ref;
		logic [31:0] last_seen;
	} entry_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic valid;     // cell position is below the entry count
		logic wr;        // load the announced entry
		logic shift;     // take the entry of the upper neighbor
		logic exp_load;  // capture the expired flag for a sweep
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/ptl_cell.sv
// ptl_cell: one table position; holds an entry and its expired flag
// depends on ptl_pkg; a row of these is built by peer_table_lru_ttl
`default_nettype none

module ptl_cell (
	input  wire              clk,
	input  ptl_pkg::cell_ctl_t ctl,
	input  ptl_pkg::entry_t  new_entry,
	input  wire [31:0]       ttl,
	input  ptl_pkg::entry_t  nxt_entry,
	input  wire              nxt_exp,
	output ptl_pkg::entry_t  entry,
	output logic             exp,
	output logic             hit
);
	import ptl_pkg::*;

	entry_t      entry_q;
	logic        exp_q;
	logic [31:0] age;
	logic        aged;

	// id match and wrap-safe age against the ttl
	assign hit  = ctl.valid && (entry_q.id == new_entry.id);
	assign age  = new_entry.last_seen - entry_q.last_seen;
	assign aged = (age >= ttl);

	// entry storage: load on announce, take neighbor on compaction
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			entry_q <= new_entry;
		end else if (ctl.shift) begin
			entry_q <= nxt_entry;
		end
	end

	// expired flag travels with its entry while compacting
	always_ff @(posedge clk) begin
		if (ctl.exp_load) begin
			exp_q <= ctl.valid && aged;
		end else if (ctl.shift) begin
			exp_q <= nxt_exp;
		end
	end

	assign entry = entry_q;
	assign exp   = exp_q;

endmodule

`default_nettype wire

>>> sv/peer_table_lru_ttl.sv
// peer_table_lru_ttl: refresh, insert, drop and read load their result in the exec step after
// the input transfer; an eviction adds an lru scan with one step per entry after the first, a
// sweep adds one compaction shift per removed entry and a final step; a result waiting for
// transfer holds the item in its first step. one item at a time: a new item is taken only in idle.
// arst_n clears entry count, configuration registers and handshake state; entries hold
// whatever was last written.
// depends on ptl_pkg and ptl_cell
`default_nettype none

module peer_table_lru_ttl #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	input  ptl_pkg::in_item_t   item,
	output logic                result_valid,
	input  wire                 result_ready,
	output ptl_pkg::out_item_t  result,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire [31:0]          cfg_data
);
	import ptl_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int SW = (CW > 4) ? CW : 4;
	localparam int XW = (CW > 5) ? CW : 5;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_SWEEP = 2'd3;

	logic [1:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] removed_q, removed_d;
	logic [CW-1:0] scan_q, scan_d;
	logic [CW-1:0] min_idx_q, min_idx_d;
	logic [31:0]   min_seen_q, min_seen_d;
	logic [31:0]   own_id_q, ttl_q;
	in_item_t      op_q;
	out_item_t     result_q, res_d;
	logic          result_valid_q, res_load;

	entry_t        cell_entry [MAX_ENTRIES];
	logic          exp_vec [MAX_ENTRIES];
	logic          hit_vec [MAX_ENTRIES];
	cell_ctl_t     ctl [MAX_ENTRIES];
	entry_t        new_entry;

	logic          res_free, drop, any_hit, full, any_exp, read_ok;
	logic          cand_less, scan_last;
	logic [CW-1:0] slot_now;
	logic [SW-1:0] rd_addr;
	entry_t        rd_entry;
	logic [XW-1:0] cnt_x, rem_x;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign res_free     = !result_valid_q || result_ready;

	assign new_entry = '{id: op_q.peer_id, ip: op_q.peer_ip,
		name_ref: op_q.name_ref, last_seen: op_q.now_ms};

	// row of cells, each handing its entry down to the lower neighbor
	for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
		if (j == MAX_ENTRIES - 1) begin : g_top
			ptl_cell u_cell (
				.clk       (clk),
				.ctl       (ctl[j]),
				.new_entry (new_entry),
				.ttl       (ttl_q),
				.nxt_entry (cell_entry[j]),
				.nxt_exp   (1'b0),
				.entry     (cell_entry[j]),
				.exp       (exp_vec[j]),
				.hit       (hit_vec[j])
			);
		end else begin : g_mid
			ptl_cell u_cell (
				.clk       (clk),
				.ctl       (ctl[j]),
				.new_entry (new_entry),
				.ttl       (ttl_q),
				.nxt_entry (cell_entry[j+1]),
				.nxt_exp   (exp_vec[j+1]),
				.entry     (cell_entry[j]),
				.exp       (exp_vec[j]),
				.hit       (hit_vec[j])
			);
		end
	end

	// table-wide flags
	always_comb begin
		any_hit = 1'b0;
		any_exp = 1'b0;
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			any_hit = any_hit | hit_vec[j];
			any_exp = any_exp | exp_vec[j];
		end
	end

	assign drop = (op_q.peer_id == 32'd0) || (op_q.peer_id == own_id_q);
	assign full = (count_q == CW'(MAX_ENTRIES));

	// single read port over the cells: scan position or requested index
	assign rd_addr = (state_q == S_SCAN) ? SW'(scan_q) : SW'(op_q.read_index);
	always_comb begin
		rd_entry = '0;
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			if (rd_addr == SW'(j)) begin
				rd_entry = rd_entry | cell_entry[j];
			end
		end
	end
	assign read_ok = SW'(op_q.read_index) < SW'(count_q);

	// lru scan step
	assign cand_less = rd_entry.last_seen < min_seen_q;
	assign slot_now  = cand_less ? scan_q : min_idx_q;
	assign scan_last = (scan_q == CW'(MAX_ENTRIES - 1));

	// per-cell control
	always_comb begin
		logic below;
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			below = 1'b0;
			for (int k = 0; k <= j; k++) begin
				below = below | exp_vec[k];
			end
			ctl[j].valid    = CW'(j) < count_q;
			ctl[j].exp_load = (state_q == S_EXEC) && res_free && (op_q.opcode == OP_SWEEP);
			ctl[j].shift    = (state_q == S_SWEEP) && below;
			ctl[j].wr       = 1'b0;
			if ((state_q == S_EXEC) && res_free && (op_q.opcode == OP_ANNOUNCE) && !drop) begin
				if (any_hit) begin
					ctl[j].wr = hit_vec[j];
				end else if (!full) begin
					ctl[j].wr = (count_q == CW'(j));
				end else begin
					ctl[j].wr = (MAX_ENTRIES == 1) && (j == 0);
				end
			end else if ((state_q == S_SCAN) && scan_last) begin
				ctl[j].wr = (slot_now == CW'(j));
			end
		end
	end

	// sequencer next state and result
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		removed_d  = removed_q;
		scan_d     = scan_q;
		min_idx_d  = min_idx_q;
		min_seen_d = min_seen_q;
		res_load   = 1'b0;
		res_d      = '0;
		res_d.status = ST_DROPPED;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (res_free) begin
					case (op_q.opcode)
						OP_ANNOUNCE: begin
							if (drop) begin
								res_load = 1'b1;
								res_d.status = ST_DROPPED;
								state_d = S_IDLE;
							end else if (any_hit) begin
								res_load = 1'b1;
								res_d.status = ST_REFRESHED;
								state_d = S_IDLE;
							end else if (!full) begin
								count_d = count_q + CW'(1);
								res_load = 1'b1;
								res_d.status = ST_INSERTED;
								state_d = S_IDLE;
							end else if (MAX_ENTRIES == 1) begin
								res_load = 1'b1;
								res_d.status = ST_EVICTED;
								state_d = S_IDLE;
							end else begin
								scan_d     = CW'(1);
								min_idx_d  = '0;
								min_seen_d = cell_entry[0].last_seen;
								state_d    = S_SCAN;
							end
						end
						OP_SWEEP: begin
							removed_d = '0;
							state_d   = S_SWEEP;
						end
						OP_READ: begin
							res_load = 1'b1;
							state_d  = S_IDLE;
							if (read_ok) begin
								res_d.status          = ST_READ_OK;
								res_d.entry_id        = rd_entry.id;
								res_d.entry_ip        = rd_entry.ip;
								res_d.entry_name_ref  = rd_entry.name_ref;
								res_d.entry_last_seen = rd_entry.last_seen;
							end else begin
								res_d.status = ST_READ_EMPTY;
							end
						end
						default: begin
							res_load = 1'b1;
							res_d.status = ST_DROPPED;
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SCAN: begin
				min_idx_d = slot_now;
				if (cand_less) begin
					min_seen_d = rd_entry.last_seen;
				end
				if (scan_last) begin
					res_load = 1'b1;
					res_d.status = ST_EVICTED;
					state_d = S_IDLE;
				end else begin
					scan_d = scan_q + CW'(1);
				end
			end
			S_SWEEP: begin
				if (any_exp) begin
					count_d   = count_q - CW'(1);
					removed_d = removed_q + CW'(1);
				end else begin
					res_load = 1'b1;
					res_d.status = ST_SWEPT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		cnt_x = XW'(count_d);
		rem_x = XW'(removed_q);
		res_d.peer_count = cnt_x[4:0];
		if (state_q == S_SWEEP) begin
			res_d.removed_count = rem_x[4:0];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			result_valid_q <= 1'b0;
			own_id_q       <= OWN_ID_RESET;
			ttl_q          <= TTL_MS_RESET;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_OWN_ID: own_id_q <= cfg_data;
					REG_TTL_MS: ttl_q    <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// item, scan and result payload
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			op_q <= item;
		end
		if (res_load) begin
			result_q <= res_d;
		end
		removed_q  <= removed_d;
		scan_q     <= scan_d;
		min_idx_q  <= min_idx_d;
		min_seen_q <= min_seen_d;
	end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// testbench for peer_table_lru_ttl: directed and random announce, sweep and read traffic
// a shadow copy of the peer table predicts every reply; needs ptl_pkg and the rtl only
`timescale 1ns / 1ps

module testbench;
	import ptl_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int POOL_SIZE = 24;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// shadow of the peer table: predicts replies and compares them in order
	class peer_table_shadow;
		logic [31:0] ids [TABLE_DEPTH];
		logic [31:0] ips [TABLE_DEPTH];
		logic [31:0] names [TABLE_DEPTH];
		logic [31:0] heard [TABLE_DEPTH];
		int unsigned count;
		logic [31:0] own_id;
		logic [31:0] ttl_ms;
		out_item_t replies_due [$];
		int errors;
		int replies;
		int status_tally [8];
		int swept_total;

		function void clear();
			count = 0;
			own_id = OWN_ID_RESET;
			ttl_ms = TTL_MS_RESET;
			errors = 0;
			replies = 0;
			swept_total = 0;
			foreach (status_tally[s])
				status_tally[s] = 0;
		endfunction

		function void set_reg(logic idx, logic [31:0] val);
			if (idx == REG_OWN_ID)
				own_id = val;
			else
				ttl_ms = val;
		endfunction

		function void put(int slot, in_item_t it);
			ids[slot] = it.peer_id;
			ips[slot] = it.peer_ip;
			names[slot] = it.name_ref;
			heard[slot] = it.now_ms;
		endfunction

		// apply one accepted request to the table and queue its reply
		function void note_item(in_item_t it);
			out_item_t reply;
			int i;
			int hit;
			int slot;
			int kept;
			logic [31:0] age;
			reply = '0;
			case (it.opcode)
				OP_ANNOUNCE: begin
					hit = -1;
					for (i = 0; i < count; i++)
						if (hit < 0 && ids[i] == it.peer_id)
							hit = i;
					if (it.peer_id == 32'd0 || it.peer_id == own_id) begin
						reply.status = ST_DROPPED;
					end else if (hit >= 0) begin
						put(hit, it);
						reply.status = ST_REFRESHED;
					end else if (count < TABLE_DEPTH) begin
						put(count, it);
						count++;
						reply.status = ST_INSERTED;
					end else begin
						// least recently heard, lowest index on ties
						slot = 0;
						for (i = 1; i < count; i++)
							if (heard[i] < heard[slot])
								slot = i;
						put(slot, it);
						reply.status = ST_EVICTED;
					end
				end
				OP_SWEEP: begin
					// keep entries younger than the ttl, packed to the front in order
					kept = 0;
					for (i = 0; i < count; i++) begin
						age = it.now_ms - heard[i];
						if (age < ttl_ms) begin
							ids[kept] = ids[i];
							ips[kept] = ips[i];
							names[kept] = names[i];
							heard[kept] = heard[i];
							kept++;
						end
					end
					reply.removed_count = 5'(count - kept);
					swept_total += count - kept;
					count = kept;
					reply.status = ST_SWEPT;
				end
				OP_READ: begin
					if (it.read_index < count) begin
						reply.status = ST_READ_OK;
						reply.entry_id = ids[it.read_index];
						reply.entry_ip = ips[it.read_index];
						reply.entry_name_ref = names[it.read_index];
						reply.entry_last_seen = heard[it.read_index];
					end else begin
						reply.status = ST_READ_EMPTY;
					end
				end
				default: begin
					reply.status = ST_DROPPED;
				end
			endcase
			reply.peer_count = 5'(count);
			status_tally[reply.status]++;
			replies_due.push_back(reply);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("mismatch on reply %0d: %s got %h want %h", replies, what, got, want);
		endtask

		task compare(string field, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report(field, got, want);
		endtask

		task check_reply(out_item_t got);
			out_item_t want;
			replies++;
			if (replies_due.size() == 0) begin
				report("reply with no request waiting, status", 32'(got.status), 32'd0);
				return;
			end
			want = replies_due.pop_front();
			compare("status", 32'(got.status), 32'(want.status));
			compare("peer_count", 32'(got.peer_count), 32'(want.peer_count));
			compare("removed_count", 32'(got.removed_count), 32'(want.removed_count));
			compare("entry_id", got.entry_id, want.entry_id);
			compare("entry_ip", got.entry_ip, want.entry_ip);
			compare("entry_name_ref", got.entry_name_ref, want.entry_name_ref);
			compare("entry_last_seen", got.entry_last_seen, want.entry_last_seen);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_item_t result;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	peer_table_shadow table_shadow;
	logic [31:0] clock_ms;
	logic [31:0] peer_pool [POOL_SIZE];
	bit send_steady = 1'b0;
	bit take_steady = 1'b0;
	int stall_left = 0;

	peer_table_lru_ttl #(
		.MAX_ENTRIES(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// mostly short pauses, a few long ones
	function automatic int pick_pause();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// reply side backpressure
	always @(posedge clk) begin
		if (take_steady) begin
			result_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 75) begin
			result_ready <= 1'b1;
		end else begin
			stall_left = pick_pause() - 1;
			result_ready <= 1'b0;
		end
	end

	// every reply transfer goes to the shadow for checking
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			table_shadow.check_reply(result);
	end

	// one request transfer, after an optional idle gap
	task automatic send_item(input in_item_t it);
		int gap;
		gap = 0;
		if (!send_steady && $urandom_range(0, 99) >= 60)
			gap = pick_pause();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		table_shadow.note_item(it);
	endtask

	// stop sending and wait until every reply is back
	task automatic drain();
		item_valid <= 1'b0;
		while (table_shadow.replies_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_regs(input logic [31:0] own, input logic [31:0] ttl);
		cfg_we <= 1'b1;
		cfg_index <= REG_OWN_ID;
		cfg_data <= own;
		@(posedge clk);
		table_shadow.set_reg(REG_OWN_ID, own);
		cfg_index <= REG_TTL_MS;
		cfg_data <= ttl;
		@(posedge clk);
		table_shadow.set_reg(REG_TTL_MS, ttl);
		cfg_we <= 1'b0;
	endtask

	// request with random payload at the current time
	function automatic in_item_t noise_item(logic [1:0] op);
		in_item_t it;
		it.opcode = op;
		it.peer_id = $urandom;
		it.peer_ip = $urandom;
		it.name_ref = $urandom;
		it.now_ms = clock_ms;
		it.read_index = 4'($urandom_range(0, 15));
		return it;
	endfunction

	// empty table, drops, a full table with tied times, wrap and zero ttl
	task automatic run_directed();
		in_item_t it;
		int k;
		set_regs(32'hFFFF_FFFF, TTL_MS_RESET);
		clock_ms = 32'hFFFF_FFF0;
		it = noise_item(OP_READ);
		it.read_index = 4'd0;
		send_item(it);
		send_item(noise_item(OP_SWEEP));
		send_item(noise_item(OP_UNUSED));
		it = noise_item(OP_ANNOUNCE);
		it.peer_id = 32'd0;
		send_item(it);
		it = noise_item(OP_ANNOUNCE);
		it.peer_id = 32'hFFFF_FFFF;
		send_item(it);
		// fill the table, all heard at the same time
		for (k = 0; k < TABLE_DEPTH; k++) begin
			it = noise_item(OP_ANNOUNCE);
			it.peer_id = 32'hFFFF_FFFE - k;
			if (k == 0) begin
				it.peer_ip = 32'd0;
				it.name_ref = 32'd0;
			end else if (k == 1) begin
				it.peer_ip = 32'hFFFF_FFFF;
				it.name_ref = 32'hFFFF_FFFF;
			end
			send_item(it);
		end
		// time wraps; a new id on a full table evicts the first of the ties
		clock_ms = 32'h0000_0010;
		it = noise_item(OP_ANNOUNCE);
		it.peer_id = 32'd1;
		send_item(it);
		it = noise_item(OP_READ);
		it.read_index = 4'd15;
		send_item(it);
		it = noise_item(OP_ANNOUNCE);
		it.peer_id = 32'hFFFF_FFFE - 5;
		send_item(it);
		// wrap-safe age: only the two entries heard after the wrap survive
		drain();
		set_regs(32'hFFFF_FFFF, 32'h20);
		clock_ms = 32'h0000_0020;
		send_item(noise_item(OP_SWEEP));
		it = noise_item(OP_READ);
		it.read_index = 4'd1;
		send_item(it);
		// zero ttl empties the table
		drain();
		set_regs(32'd0, 32'd0);
		send_item(noise_item(OP_SWEEP));
	endtask

	// random traffic from a small id pool so that refreshes and evictions are common
	task automatic run_phase(input int items, input logic [31:0] own, input logic [31:0] ttl,
			input logic [31:0] start_ms);
		in_item_t it;
		int n;
		int r;
		int step_cap;
		drain();
		set_regs(own, ttl);
		clock_ms = start_ms;
		step_cap = (ttl > 32'd16000) ? 500 : int'(ttl / 32) + 1;
		foreach (peer_pool[p])
			peer_pool[p] = $urandom;
		if (own != 32'd0)
			peer_pool[0] = own;
		for (n = 0; n < items; n++) begin
			if (n % 40 == 0) begin
				send_steady = ($urandom_range(0, 3) == 0);
				take_steady = ($urandom_range(0, 3) == 0);
			end
			// time moves forward mostly, sometimes stands still, steps back or jumps
			r = $urandom_range(0, 99);
			if (r < 5)
				clock_ms = clock_ms - 1;
			else if (r < 8)
				clock_ms = $urandom;
			else if (r >= 20)
				clock_ms = clock_ms + $urandom_range(0, step_cap);
			r = $urandom_range(0, 99);
			if (r < 52) begin
				it = noise_item(OP_ANNOUNCE);
				it.peer_id = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
			end else if (r < 55) begin
				it = noise_item(OP_ANNOUNCE);
				it.peer_id = $urandom_range(0, 1) ? 32'd0 : table_shadow.own_id;
			end else if (r < 66) begin
				it = noise_item(OP_SWEEP);
			end else if (r < 97) begin
				it = noise_item(OP_READ);
				if ($urandom_range(0, 1) && table_shadow.count > 0)
					it.read_index = 4'($urandom_range(0, table_shadow.count - 1));
			end else begin
				it = noise_item(OP_UNUSED);
			end
			send_item(it);
		end
	endtask

	initial begin
		table_shadow = new;
		table_shadow.clear();
		clock_ms = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_phase(260, $urandom, $urandom_range(200, 4000), $urandom);
		run_phase(150, 32'd0, 32'd1, $urandom);
		run_phase(150, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom);
		run_phase(260, $urandom, $urandom_range(50, 5000), 32'hFFFF_FFFF - $urandom_range(0, 3000));
		run_phase(130, $urandom, $urandom, $urandom);
		drain();
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		$display("covered %0d replies: %0d inserts, %0d refreshes, %0d evictions, %0d drops",
			table_shadow.replies, table_shadow.status_tally[ST_INSERTED],
			table_shadow.status_tally[ST_REFRESHED], table_shadow.status_tally[ST_EVICTED],
			table_shadow.status_tally[ST_DROPPED]);
		$display("%0d sweeps expired %0d entries; %0d reads hit, %0d missed",
			table_shadow.status_tally[ST_SWEPT], table_shadow.swept_total,
			table_shadow.status_tally[ST_READ_OK], table_shadow.status_tally[ST_READ_EMPTY]);
		if (table_shadow.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog well beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("timeout with %0d replies outstanding", table_shadow.replies_due.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
